FILE: rtl/uwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Whitelist package
// Shared constants, codes and types of the mixed-width card ID whitelist.
// ----------------------------------------------------------------------------
package uwl_pkg;

  localparam int UID_W       = 56;
  localparam int SHORT_W     = 32;
  localparam int SLOTS       = 7;
  localparam int SHORT_SLOTS = 7;
  localparam int LONG_SLOTS  = 4;
  localparam int MAX_BLOCKS  = 32;
  localparam int DEF_BLOCKS  = 32;
  localparam int ROW_W       = SLOTS * UID_W;

  typedef logic [SLOTS-1:0][UID_W-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_LOOKUP   = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_STORED    = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_MASTER    = 3'd2,
    STS_FULL      = 3'd3,
    STS_ZERO      = 3'd4,
    STS_FOUND     = 3'd5,
    STS_NOT_FOUND = 3'd6,
    STS_CLEARED   = 3'd7
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] hit_slot;
    logic       free;
    logic [2:0] free_slot;
  } row_info_t;

endpackage
`default_nettype wire

FILE: rtl/mixed_width_uid_whitelist_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixed-width card ID whitelist
// Clear, zero and unused items answer in the cycle after start; lookups
// scan one block per cycle, registers up to twice (duplicate pass, free pass).
// One item at a time; busy is high while a scan runs. Results cannot be stalled.
// Synchronous reset empties the table at once via the block occupancy map.
// ----------------------------------------------------------------------------
module mixed_width_uid_whitelist_top #(
  parameter int NUM_BLOCKS = uwl_pkg::DEF_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        master_uid_we,
  input  wire logic [uwl_pkg::UID_W-1:0]   master_uid,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [1:0]                  action,
  input  wire logic [uwl_pkg::UID_W-1:0]   uid,
  input  wire logic                        uid_is_long,
  output      logic                        done,
  output      logic [2:0]                  status,
  output      logic [4:0]                  block_number,
  output      logic [2:0]                  slot_number,
  output      logic [7:0]                  stored_count
);
  import uwl_pkg::*;

  localparam int SB = (NUM_BLOCKS < MAX_BLOCKS) ? NUM_BLOCKS : MAX_BLOCKS;
  localparam int BW = (SB > 1) ? $clog2(SB) : 1;
  localparam int CW = $clog2(SB + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_FREE = 3'b100
  } state_t;

  state_t            state;
  logic [UID_W-1:0]  master_reg;
  logic [UID_W-1:0]  key;
  logic              is_long;
  action_t           act;
  logic [SB-1:0]     occ_map;
  logic [SB-1:0]     long_map;
  logic [7:0]        count;
  logic [CW-1:0]     rd_cnt;
  logic              chk_vld;
  logic [BW-1:0]     chk_blk;
  row_t              rd_data;
  row_t              row;
  row_t              wr_row;
  row_info_t         info;
  logic              rd_en;
  logic              wr_en;
  logic              last;
  logic              occ_bit;
  logic              type_ok;
  logic [UID_W-1:0]  in_key;
  logic [UID_W-1:0]  mkey;

  assign in_key = uid_is_long ? uid : {{(UID_W-SHORT_W){1'b0}}, uid[UID_W-1 -: SHORT_W]};
  assign mkey   = is_long ? master_reg
                          : {{(UID_W-SHORT_W){1'b0}}, master_reg[UID_W-1 -: SHORT_W]};
  assign busy   = (state != S_IDLE);
  assign rd_en  = (state != S_IDLE) && (rd_cnt < CW'(SB));
  assign last   = (chk_blk == BW'(SB - 1));
  assign occ_bit = occ_map[chk_blk];
  assign type_ok = (long_map[chk_blk] == is_long);
  assign row    = occ_bit ? rd_data : '0;
  assign stored_count = count;

  always_comb begin
    wr_row = row;
    wr_row[info.free_slot] = key;
  end

  assign wr_en = (state == S_FREE) && chk_vld && (!occ_bit || type_ok) && info.free;

  uwl_mem #(.DEPTH(SB), .AW(BW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt[BW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (chk_blk),
    .wr_data (wr_row)
  );

  uwl_row_check u_check (
    .row     (row),
    .key     (key),
    .is_long (is_long),
    .info    (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      master_reg <= '0;
    end else if (master_uid_we) begin
      master_reg <= master_uid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ_map  <= '0;
      long_map <= '0;
      count    <= '0;
      done     <= 1'b0;
      chk_vld  <= 1'b0;
      rd_cnt   <= '0;
    end else begin
      done    <= 1'b0;
      chk_vld <= rd_en;
      if (rd_en) begin
        rd_cnt  <= rd_cnt + 1'b1;
        chk_blk <= rd_cnt[BW-1:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            act          <= action_t'(action);
            key          <= in_key;
            is_long      <= uid_is_long;
            rd_cnt       <= '0;
            block_number <= '0;
            slot_number  <= '0;
            case (action_t'(action))
              ACT_CLEAR: begin
                occ_map  <= '0;
                long_map <= '0;
                count    <= '0;
                status   <= STS_CLEARED;
                done     <= 1'b1;
              end
              ACT_REGISTER, ACT_LOOKUP: begin
                if (in_key == '0) begin
                  status <= (action_t'(action) == ACT_LOOKUP) ? STS_NOT_FOUND : STS_ZERO;
                  done   <= 1'b1;
                end else begin
                  state <= S_FIND;
                end
              end
              default: begin
                status <= STS_NOT_FOUND;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_FIND: begin
          if (chk_vld) begin
            if (occ_bit && type_ok && info.hit) begin
              status       <= (act == ACT_LOOKUP) ? STS_FOUND : STS_PRESENT;
              block_number <= 5'(chk_blk);
              slot_number  <= info.hit_slot;
              done         <= 1'b1;
              state        <= S_IDLE;
            end else if (last) begin
              if (act == ACT_LOOKUP || key == mkey) begin
                status <= (act == ACT_LOOKUP) ? STS_NOT_FOUND : STS_MASTER;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                rd_cnt  <= '0;
                state   <= S_FREE;
              end
            end
          end
        end
        S_FREE: begin
          if (chk_vld) begin
            if (wr_en) begin
              occ_map[chk_blk]  <= 1'b1;
              long_map[chk_blk] <= is_long;
              if (count != 8'hFF) begin
                count <= count + 8'd1;
              end
              status       <= STS_STORED;
              block_number <= 5'(chk_blk);
              slot_number  <= info.free_slot;
              done         <= 1'b1;
              state        <= S_IDLE;
            end else if (last) begin
              status <= STS_FULL;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/uwl_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Whitelist slot memory
// One row per block holding all slots; registered read, one write port.
// ----------------------------------------------------------------------------
module uwl_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output      uwl_pkg::row_t        rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire uwl_pkg::row_t        wr_data
);
  import uwl_pkg::*;

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/uwl_row_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Whitelist row check
// Finds the first matching slot and the first empty slot of one block row (long IDs: first LONG_SLOTS only).
// ----------------------------------------------------------------------------
module uwl_row_check (
  input  wire uwl_pkg::row_t                row,
  input  wire logic [uwl_pkg::UID_W-1:0]    key,
  input  wire logic                         is_long,
  output      uwl_pkg::row_info_t           info
);
  import uwl_pkg::*;

  always_comb begin
    info = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (s < LONG_SLOTS || !is_long) begin
        if (row[s] == key) begin
          info.hit      = 1'b1;
          info.hit_slot = 3'(s);
        end
        if (row[s] == '0) begin
          info.free      = 1'b1;
          info.free_slot = 3'(s);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_mixed_width_uid_whitelist_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whitelist testbench
// Drives register, lookup, clear and unused items into the card ID whitelist,
// predicts each answer from a behavioral copy of the table, and compares every
// result field by field in order of arrival.
// ----------------------------------------------------------------------------

class uwl_scoreboard;
  logic [55:0] master_key;
  logic [55:0] slot_mem [0:223];
  logic [31:0] occ_map;
  logic [31:0] long_map;
  logic [7:0]  card_total;
  logic [2:0]  want_status [$];
  logic [4:0]  want_block [$];
  logic [2:0]  want_slot [$];
  logic [7:0]  want_count [$];
  int          errors;

  function new();
    master_key = '0;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < 224; i++) slot_mem[i] = '0;
    occ_map = '0;
    long_map = '0;
    card_total = '0;
  endfunction

  function bit search(logic [55:0] key, bit is_long, output int fb, output int fs);
    int n;
    n = is_long ? uwl_pkg::LONG_SLOTS : uwl_pkg::SHORT_SLOTS;
    fb = 0;
    fs = 0;
    if (key == 0) return 0;
    for (int b = 0; b < 32; b++) begin
      if (!occ_map[b] || long_map[b] != is_long) continue;
      for (int s = 0; s < n; s++) begin
        if (slot_mem[b*7+s] == key) begin
          fb = b;
          fs = s;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function void note_item(logic [1:0] act, logic [55:0] id, bit is_long);
    logic [55:0] key, mkey;
    uwl_pkg::status_t st;
    int fb, fs, n;
    bit placed;
    key = is_long ? id : {24'd0, id[55:24]};
    mkey = is_long ? master_key : {24'd0, master_key[55:24]};
    st = uwl_pkg::STS_NOT_FOUND;
    fb = 0;
    fs = 0;
    if (act == uwl_pkg::ACT_CLEAR) begin
      wipe();
      st = uwl_pkg::STS_CLEARED;
    end else if (act == uwl_pkg::ACT_LOOKUP) begin
      if (search(key, is_long, fb, fs)) st = uwl_pkg::STS_FOUND;
    end else if (act == uwl_pkg::ACT_REGISTER) begin
      if (key == 0) st = uwl_pkg::STS_ZERO;
      else if (search(key, is_long, fb, fs)) st = uwl_pkg::STS_PRESENT;
      else if (key == mkey) st = uwl_pkg::STS_MASTER;
      else begin
        st = uwl_pkg::STS_FULL;
        n = is_long ? uwl_pkg::LONG_SLOTS : uwl_pkg::SHORT_SLOTS;
        placed = 0;
        for (int b = 0; b < 32 && !placed; b++) begin
          if (occ_map[b] && long_map[b] != is_long) continue;
          for (int s = 0; s < n && !placed; s++) begin
            if (slot_mem[b*7+s] == 0) begin
              slot_mem[b*7+s] = key;
              occ_map[b] = 1'b1;
              long_map[b] = is_long;
              if (card_total != 8'hff) card_total++;
              st = uwl_pkg::STS_STORED;
              fb = b;
              fs = s;
              placed = 1;
            end
          end
        end
      end
    end
    want_status.push_back(st);
    want_block.push_back(fb[4:0]);
    want_slot.push_back(fs[2:0]);
    want_count.push_back(card_total);
  endfunction

  function void check_result(logic [2:0] st, logic [4:0] bn, logic [2:0] sn,
                             logic [7:0] cnt);
    logic [2:0] es, ens;
    logic [4:0] eb;
    logic [7:0] ec;
    if (want_status.size() == 0) begin
      $display("%0t: result with none expected: status %0d", $time, st);
      errors++;
      return;
    end
    es = want_status.pop_front();
    eb = want_block.pop_front();
    ens = want_slot.pop_front();
    ec = want_count.pop_front();
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
    if (bn !== eb) begin
      $display("%0t: block_number expected %0d actual %0d", $time, eb, bn);
      errors++;
    end
    if (sn !== ens) begin
      $display("%0t: slot_number expected %0d actual %0d", $time, ens, sn);
      errors++;
    end
    if (cnt !== ec) begin
      $display("%0t: stored_count expected %0d actual %0d", $time, ec, cnt);
      errors++;
    end
  endfunction
endclass

module tb_mixed_width_uid_whitelist_top;
  import uwl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        master_uid_we = 1'b0;
  logic [55:0] master_uid = '0;
  logic        start = 1'b0;
  logic [1:0]  action = '0;
  logic [55:0] uid = '0;
  logic        uid_is_long = 1'b0;
  logic        busy, done;
  logic [2:0]  status;
  logic [4:0]  block_number;
  logic [2:0]  slot_number;
  logic [7:0]  stored_count;
  longint      cycles = 0;
  int          burst_left = 0;
  logic [55:0] id_pool [$];
  logic        pool_long [$];

  uwl_scoreboard table_model = new();

  mixed_width_uid_whitelist_top dut (
    .clk(clk), .rst(rst), .master_uid_we(master_uid_we), .master_uid(master_uid),
    .start(start), .busy(busy), .action(action), .uid(uid),
    .uid_is_long(uid_is_long), .done(done), .status(status),
    .block_number(block_number), .slot_number(slot_number),
    .stored_count(stored_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) table_model.check_result(status, block_number, slot_number, stored_count);
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [55:0] id, bit is_long);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    action <= act;
    uid <= id;
    uid_is_long <= is_long;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_model.note_item(act, id, is_long);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (table_model.want_status.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_master(logic [55:0] value);
    drain();
    master_uid_we <= 1'b1;
    master_uid <= value;
    @(negedge clk);
    master_uid_we <= 1'b0;
    table_model.master_key = value;
  endtask

  function automatic logic [55:0] rand_id();
    return 56'({$urandom(), $urandom()});
  endfunction

  task automatic random_item();
    int pick, k;
    logic [55:0] id;
    bit lg;
    pick = $urandom_range(0, 99);
    lg = $urandom_range(0, 1);
    id = rand_id();
    if (id_pool.size() != 0 && $urandom_range(0, 1)) begin
      k = $urandom_range(0, id_pool.size() - 1);
      id = id_pool[k];
      lg = pool_long[k];
      if (!lg) id[23:0] = 24'($urandom());
    end
    if (pick < 55) begin
      send_item(ACT_REGISTER, id, lg);
      id_pool.push_back(id);
      pool_long.push_back(lg);
    end else if (pick < 93) send_item(ACT_LOOKUP, id, lg);
    else if (pick < 96) send_item(ACT_UNUSED, id, lg);
    else if (pick < 98) send_item(ACT_REGISTER, $urandom_range(0, 1) ? 56'd0 : 56'h0000_0000_ffffff, lg);
    else begin
      send_item(ACT_CLEAR, id, lg);
      id_pool.delete();
      pool_long.delete();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_master(56'h12_3456_78ab_cdef);
    send_item(ACT_REGISTER, 56'd0, 1'b1);
    send_item(ACT_REGISTER, 56'h00_0000_00ff_ffff, 1'b0);
    send_item(ACT_LOOKUP, 56'd0, 1'b0);
    send_item(ACT_REGISTER, 56'h12_3456_78ab_cdef, 1'b1);
    send_item(ACT_REGISTER, 56'h12_3456_7800_0001, 1'b0);
    send_item(ACT_REGISTER, 56'hff_ffff_ffff_ffff, 1'b1);
    send_item(ACT_REGISTER, 56'hff_ffff_ffff_ffff, 1'b1);
    send_item(ACT_REGISTER, 56'hff_ffff_ff00_0000, 1'b0);
    send_item(ACT_REGISTER, 56'hff_ffff_ff12_3456, 1'b0);
    send_item(ACT_LOOKUP, 56'hff_ffff_ffaa_aaaa, 1'b0);
    send_item(ACT_LOOKUP, 56'hff_ffff_ffff_ffff, 1'b1);
    send_item(ACT_LOOKUP, 56'h00_0000_0000_0001, 1'b1);
    send_item(ACT_UNUSED, 56'hff_ffff_ffff_ffff, 1'b1);
    send_item(ACT_CLEAR, 56'd0, 1'b0);
    send_item(ACT_LOOKUP, 56'hff_ffff_ffff_ffff, 1'b1);

    // Fill the table to the brim with short IDs, then probe both widths.
    set_master(56'hff_ffff_ffff_ffff);
    for (int i = 1; i <= 226; i++) send_item(ACT_REGISTER, {i[31:0], 24'h5a5a5a}, 1'b0);
    send_item(ACT_REGISTER, 56'h00_0000_0000_0007, 1'b1);
    send_item(ACT_LOOKUP, {32'd224, 24'd0}, 1'b0);
    send_item(ACT_REGISTER, 56'hff_ffff_ff00_0000, 1'b0);
    send_item(ACT_CLEAR, 56'd0, 1'b0);
    set_master(56'h00_0000_0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 110; i++) random_item();
      if (phase == 1) set_master(id_pool.size() != 0 ? id_pool[0] : rand_id());
      else if (phase == 2) set_master(rand_id());
      else drain();
    end

    drain();
    if (table_model.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
